>>> hw/rtl/sorted_delay_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// Sorted delay timer queue assertion macros
// Shared property forms for the checker, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SORTED_DELAY_TIMER_QUEUE_ASSERT_SVH
`define SORTED_DELAY_TIMER_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDTQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted delay timer queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define SDTQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted delay timer queue check failed");

`endif

>>> hw/rtl/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted delay timer queue package
// Request codes, status codes, entry and result types shared by the block.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int TICK_W  = 64;
  localparam int DELAY_W = 32;
  localparam int ID_W    = 8;
  localparam int PRIO_W  = 8;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam int WAKE_W = 5;
  localparam logic [WAKE_W-1:0] MAX_WAKE = 5'd16;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   task_id;
  } entry_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] task_id;
    logic            woken;
    logic [1:0]      status;
    logic            last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_HEAD,
    ST_REM,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_TICK_FLUSH
  } state_t;

endpackage

>>> hw/rtl/sorted_delay_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted delay timer queue
// Usage:
// A request is taken when start is high and busy is low. Mode insert adds a
// task that wakes at tick_count + delay_ticks, mode remove deletes a task by
// id, and mode tick advances the 64-bit tick counter and wakes expired tasks.
// Each result sits on the result ports for one cycle, marked by valid, with
// last set on the final result of its request; the receiver cannot stall.
// Results are registered and appear the cycle after the controller makes them.
// Rejected requests, inserts into an empty queue and removes from an empty
// queue answer the cycle after acceptance without raising busy. An insert
// walks from the tail toward the head, shifting each later entry up, and
// writes the new task where it lands; remove always walks every entry,
// since the table walk moves one entry per cycle through the single read port.
// A tick pops expired heads in order, waking at most 16 tasks per tick.
// Back-to-back results of one tick come out on consecutive cycles.
// Reset clears the tick counter and empties the queue.
// ----------------------------------------------------------------------------
module sorted_delay_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [sdtq_pkg::ID_W-1:0]     task_id,
  input  logic [sdtq_pkg::PRIO_W-1:0]   task_priority,
  input  logic [sdtq_pkg::DELAY_W-1:0]  delay_ticks,
  output logic                          valid,
  output logic [sdtq_pkg::ID_W-1:0]     result_task,
  output logic                          woken,
  output logic [1:0]                    status,
  output logic                          last,
  output logic [sdtq_pkg::TICK_W-1:0]   now_ticks
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [sdtq_pkg::TICK_W-1:0] tick_count;
  logic                        tick_inc;
  sdtq_pkg::result_t           res;
  logic                        mem_we;
  logic [PTR_W-1:0]            mem_waddr;
  logic [PTR_W-1:0]            mem_raddr;
  sdtq_pkg::entry_t            mem_wdata;
  sdtq_pkg::entry_t            mem_rdata;

  sdtq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .mode          (mode),
    .task_id       (task_id),
    .task_priority (task_priority),
    .delay_ticks   (delay_ticks),
    .tick_count    (tick_count),
    .busy          (busy),
    .tick_inc      (tick_inc),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  sdtq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      valid      <= 1'b0;
    end else begin
      if (tick_inc) begin
        tick_count <= tick_count + 1'b1;
      end
      valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result_task <= res.task_id;
      woken       <= res.woken;
      status      <= res.status;
      last        <= res.last;
      now_ticks   <= tick_count;
    end
  end

endmodule

>>> hw/rtl/sdtq_ram.sv
// ----------------------------------------------------------------------------
// Sorted delay timer queue entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdtq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  sdtq_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output sdtq_pkg::entry_t rdata
);

  sdtq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sdtq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted delay timer queue controller
// Walks the circular entry table one entry per cycle to insert, remove and
// pop expired heads.
// ----------------------------------------------------------------------------
module sdtq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PTR_W       = 4,
  parameter int CNT_W       = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    mode,
  input  logic [sdtq_pkg::ID_W-1:0]     task_id,
  input  logic [sdtq_pkg::PRIO_W-1:0]   task_priority,
  input  logic [sdtq_pkg::DELAY_W-1:0]  delay_ticks,
  input  logic [sdtq_pkg::TICK_W-1:0]   tick_count,
  output logic                          busy,
  output logic                          tick_inc,
  output sdtq_pkg::result_t             res,
  output logic                          mem_we,
  output logic [PTR_W-1:0]              mem_waddr,
  output sdtq_pkg::entry_t              mem_wdata,
  output logic [PTR_W-1:0]              mem_raddr,
  input  sdtq_pkg::entry_t              mem_rdata
);

  localparam logic [PTR_W:0]   DEPTH_P   = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  sdtq_pkg::state_t state, state_next;

  logic [PTR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [PTR_W-1:0]  walk, walk_next;
  logic              walk_valid, walk_valid_next;
  logic              pend, pend_next;
  logic [PTR_W-1:0]  pend_idx, pend_idx_next;
  logic              found, found_next;
  logic [sdtq_pkg::WAKE_W-1:0] wake_n, wake_n_next;
  logic              held_valid, held_valid_next;
  logic [sdtq_pkg::ID_W-1:0] held_task, held_task_next;
  sdtq_pkg::entry_t  new_entry, new_entry_next;

  logic              accept;
  logic              goes_before;
  logic              expired;
  logic              id_match;
  logic [PTR_W-1:0]  last_idx;
  logic [sdtq_pkg::TICK_W-1:0] deadline_calc;

  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                           input logic [PTR_W-1:0] idx);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= DEPTH_P) begin
      sum = sum - DEPTH_P;
    end
    return sum[PTR_W-1:0];
  endfunction

  assign accept        = start && (state == sdtq_pkg::ST_IDLE);
  assign busy          = (state != sdtq_pkg::ST_IDLE);
  assign last_idx      = PTR_W'(count - ONE_CNT);
  assign deadline_calc = tick_count + {{(sdtq_pkg::TICK_W - sdtq_pkg::DELAY_W){1'b0}},
                                       delay_ticks};
  assign goes_before   = (mem_rdata.deadline < new_entry.deadline) ||
                         ((mem_rdata.deadline == new_entry.deadline) &&
                          (mem_rdata.prio >= new_entry.prio));
  assign expired       = (mem_rdata.deadline <= tick_count);
  assign id_match      = (mem_rdata.task_id == new_entry.task_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sdtq_pkg::ST_IDLE;
      head       <= '0;
      count      <= '0;
      walk_valid <= 1'b0;
      pend       <= 1'b0;
      found      <= 1'b0;
      wake_n     <= '0;
      held_valid <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      count      <= count_next;
      walk_valid <= walk_valid_next;
      pend       <= pend_next;
      found      <= found_next;
      wake_n     <= wake_n_next;
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    walk      <= walk_next;
    pend_idx  <= pend_idx_next;
    held_task <= held_task_next;
    new_entry <= new_entry_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    walk_next       = walk;
    walk_valid_next = walk_valid;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    found_next      = found;
    wake_n_next     = wake_n;
    held_valid_next = held_valid;
    held_task_next  = held_task;
    new_entry_next  = new_entry;
    tick_inc        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = phys(head, '0);
    mem_wdata       = new_entry;
    mem_raddr       = phys(head, walk);
    res             = '0;

    case (state)
      sdtq_pkg::ST_IDLE: begin
        if (accept) begin
          new_entry_next.deadline = deadline_calc;
          new_entry_next.prio     = task_priority;
          new_entry_next.task_id  = task_id;
          res.task_id             = task_id;
          res.last                = 1'b1;
          case (mode)
            sdtq_pkg::MODE_INSERT: begin
              if (count == FULL_CNT) begin
                res.valid  = 1'b1;
                res.status = sdtq_pkg::STATUS_FULL;
              end else if (count == '0) begin
                mem_we               = 1'b1;
                mem_wdata.deadline   = deadline_calc;
                mem_wdata.prio       = task_priority;
                mem_wdata.task_id    = task_id;
                count_next           = ONE_CNT;
                res.valid            = 1'b1;
                res.status           = sdtq_pkg::STATUS_OK;
              end else begin
                walk_next       = last_idx;
                walk_valid_next = 1'b1;
                pend_next       = 1'b0;
                state_next      = sdtq_pkg::ST_INS;
              end
            end
            sdtq_pkg::MODE_REMOVE: begin
              if (count == '0) begin
                res.valid  = 1'b1;
                res.status = sdtq_pkg::STATUS_MISS;
              end else begin
                walk_next       = '0;
                walk_valid_next = 1'b1;
                pend_next       = 1'b0;
                found_next      = 1'b0;
                state_next      = sdtq_pkg::ST_REM;
              end
            end
            sdtq_pkg::MODE_TICK: begin
              tick_inc        = 1'b1;
              wake_n_next     = '0;
              held_valid_next = 1'b0;
              state_next      = sdtq_pkg::ST_TICK_RD;
            end
            default: begin
              res.valid  = 1'b1;
              res.status = sdtq_pkg::STATUS_MISS;
            end
          endcase
        end
      end

      sdtq_pkg::ST_INS: begin
        pend_next       = walk_valid;
        pend_idx_next   = walk;
        walk_valid_next = walk_valid && (walk != '0);
        walk_next       = walk - 1'b1;
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head, pend_idx + 1'b1);
          if (goes_before) begin
            mem_wdata   = new_entry;
            count_next  = count + ONE_CNT;
            res.valid   = 1'b1;
            res.task_id = new_entry.task_id;
            res.status  = sdtq_pkg::STATUS_OK;
            res.last    = 1'b1;
            state_next  = sdtq_pkg::ST_IDLE;
          end else begin
            mem_wdata = mem_rdata;
            if (pend_idx == '0) begin
              state_next = sdtq_pkg::ST_INS_HEAD;
            end
          end
        end
      end

      sdtq_pkg::ST_INS_HEAD: begin
        mem_we      = 1'b1;
        mem_waddr   = head;
        mem_wdata   = new_entry;
        count_next  = count + ONE_CNT;
        res.valid   = 1'b1;
        res.task_id = new_entry.task_id;
        res.status  = sdtq_pkg::STATUS_OK;
        res.last    = 1'b1;
        state_next  = sdtq_pkg::ST_IDLE;
      end

      sdtq_pkg::ST_REM: begin
        pend_next       = walk_valid;
        pend_idx_next   = walk;
        walk_valid_next = walk_valid && (walk != last_idx);
        walk_next       = walk + 1'b1;
        if (pend) begin
          found_next = found || id_match;
          if (found) begin
            mem_we    = 1'b1;
            mem_waddr = phys(head, pend_idx - 1'b1);
            mem_wdata = mem_rdata;
          end
          if (pend_idx == last_idx) begin
            res.valid   = 1'b1;
            res.task_id = new_entry.task_id;
            res.last    = 1'b1;
            if (found || id_match) begin
              count_next = count - ONE_CNT;
              res.status = sdtq_pkg::STATUS_OK;
            end else begin
              res.status = sdtq_pkg::STATUS_MISS;
            end
            state_next = sdtq_pkg::ST_IDLE;
          end
        end
      end

      sdtq_pkg::ST_TICK_RD: begin
        mem_raddr = head;
        if (count == '0) begin
          res.valid  = 1'b1;
          res.status = sdtq_pkg::STATUS_OK;
          res.last   = 1'b1;
          state_next = sdtq_pkg::ST_IDLE;
        end else begin
          state_next = sdtq_pkg::ST_TICK_CMP;
        end
      end

      sdtq_pkg::ST_TICK_CMP: begin
        mem_raddr = phys(head, PTR_W'(1));
        if (expired) begin
          head_next       = (head == LAST_PTR) ? '0 : head + 1'b1;
          count_next      = count - ONE_CNT;
          wake_n_next     = wake_n + 1'b1;
          held_valid_next = 1'b1;
          held_task_next  = mem_rdata.task_id;
          if (held_valid) begin
            res.valid   = 1'b1;
            res.task_id = held_task;
            res.woken   = 1'b1;
            res.status  = sdtq_pkg::STATUS_OK;
          end
          if ((count == ONE_CNT) || (wake_n == sdtq_pkg::MAX_WAKE - 1'b1)) begin
            state_next = sdtq_pkg::ST_TICK_FLUSH;
          end
        end else begin
          res.valid   = 1'b1;
          res.task_id = held_valid ? held_task : '0;
          res.woken   = held_valid;
          res.status  = sdtq_pkg::STATUS_OK;
          res.last    = 1'b1;
          state_next  = sdtq_pkg::ST_IDLE;
        end
      end

      sdtq_pkg::ST_TICK_FLUSH: begin
        res.valid   = 1'b1;
        res.task_id = held_task;
        res.woken   = 1'b1;
        res.status  = sdtq_pkg::STATUS_OK;
        res.last    = 1'b1;
        state_next  = sdtq_pkg::ST_IDLE;
      end

      default: begin
        state_next = sdtq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/sdtq_checker.sv
// ----------------------------------------------------------------------------
// Sorted delay timer queue port checker
// Watches the top-level ports for tick bursts and request sequencing.
// ----------------------------------------------------------------------------
`include "sorted_delay_timer_queue_assert.svh"

module sdtq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    mode,
  input logic                          valid,
  input logic                          woken,
  input logic [1:0]                    status,
  input logic                          last,
  input logic [sdtq_pkg::TICK_W-1:0]   now_ticks
);

  `SDTQ_ASSERT_NEXT(a_tick_busy, start && !busy && (mode == sdtq_pkg::MODE_TICK), busy)
  `SDTQ_ASSERT_NEXT(a_burst_cont, valid && !last, valid)
  `SDTQ_ASSERT_NOW(a_burst_woken, valid && !last, woken && (status == sdtq_pkg::STATUS_OK))
  `SDTQ_ASSERT_NEXT(a_burst_time, valid && !last, now_ticks == $past(now_ticks))
  `SDTQ_ASSERT_NOW(a_burst_busy, valid && !last, busy)

endmodule

bind sorted_delay_timer_queue sdtq_checker u_sdtq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .mode      (mode),
  .valid     (valid),
  .woken     (woken),
  .status    (status),
  .last      (last),
  .now_ticks (now_ticks)
);
